[hw/rtl/twsp_pkg.sv]
package twsp_pkg;

  localparam int TILE_W  = 32;
  localparam int CFG_W   = 16;
  localparam int SLOT_W  = 4;
  // shift carried to the back end; covers window sizes up to 8
  localparam int SHIFT_W = 4;
  localparam int OFS_W   = SHIFT_W + 1;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // register select, taken from paddr[2]
  localparam logic REG_TILES_PER_ROW = 1'b0;
  localparam logic REG_DEBOUNCE_MS   = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_COPY = 2'd1,
    ACT_LOAD = 2'd2
  } act_t;

  typedef struct packed {
    logic [TILE_W-1:0] center_tile;
    logic [TILE_W-1:0] now_ms;
  } in_t;

  typedef struct packed {
    act_t              action;
    logic [SLOT_W-1:0] dest_slot;
    logic [SLOT_W-1:0] src_slot;
    logic              full_reload;
    logic              last;
  } out_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_FULL  = 2'd1,
    CMD_SHIFT = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic signed [SHIFT_W-1:0] col_shift;
    logic signed [SHIFT_W-1:0] row_shift;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE   = 2'd0,
    F_DIVIDE = 2'd1,
    F_PUSH   = 2'd2
  } front_state_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_RUN  = 1'b1
  } back_state_t;

endpackage

[hw/rtl/twsp_div.sv]
module twsp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [twsp_pkg::TILE_W-1:0] dividend,
  input  logic [twsp_pkg::CFG_W-1:0]  divisor,
  output logic                       busy,
  output logic [twsp_pkg::TILE_W-1:0] quot,
  output logic [twsp_pkg::CFG_W-1:0]  rem
);
  import twsp_pkg::*;

  localparam int CNT_W = $clog2(TILE_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [CFG_W:0]   trial;
  logic [CFG_W:0]   diff;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quot[TILE_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign busy  = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(TILE_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      if (!diff[CFG_W]) begin
        rem  <= diff[CFG_W-1:0];
        quot <= {quot[TILE_W-2:0], 1'b1};
      end else begin
        rem  <= trial[CFG_W-1:0];
        quot <= {quot[TILE_W-2:0], 1'b0};
      end
    end
  end

endmodule

[hw/rtl/twsp_front.sv]
module twsp_front #(
  parameter int WINDOW_DIM = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  twsp_pkg::in_t             item,
  output logic                      full,
  input  logic [twsp_pkg::CFG_W-1:0] tiles_per_row,
  input  logic [twsp_pkg::CFG_W-1:0] debounce_ms,
  input  logic                      q_full,
  output logic                      q_push,
  output twsp_pkg::cmd_t            q_wdata
);
  import twsp_pkg::*;

  localparam logic signed [CFG_W:0]  COL_LIM = (CFG_W + 1)'(WINDOW_DIM);
  localparam logic signed [TILE_W:0] ROW_LIM = (TILE_W + 1)'(WINDOW_DIM);

  front_state_t state, state_next;

  logic [TILE_W-1:0] prev_center;
  logic [TILE_W-1:0] last_update_time;
  logic              updated_once;
  logic              is_update;
  logic signed [CFG_W:0]  col_diff;
  logic signed [TILE_W:0] row_diff;

  logic              accept;
  logic              do_update;
  logic [TILE_W-1:0] elapsed;
  logic [CFG_W-1:0]  per_row;
  logic              div_start;
  logic              busy_new, busy_old;
  logic [TILE_W-1:0] quot_new, quot_old;
  logic [CFG_W-1:0]  rem_new, rem_old;
  logic              far;

  assign accept    = push && !full;
  assign per_row   = (tiles_per_row == '0) ? CFG_W'(1) : tiles_per_row;
  assign elapsed   = item.now_ms - last_update_time;
  assign do_update = (item.center_tile != prev_center) &&
                     (!updated_once || (elapsed > {{(TILE_W-CFG_W){1'b0}}, debounce_ms}));
  assign div_start = accept && do_update;

  // new and old centers are split in parallel
  twsp_div u_div_new (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (item.center_tile),
    .divisor  (per_row),
    .busy     (busy_new),
    .quot     (quot_new),
    .rem      (rem_new)
  );

  twsp_div u_div_old (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prev_center),
    .divisor  (per_row),
    .busy     (busy_old),
    .quot     (quot_old),
    .rem      (rem_old)
  );

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = do_update ? F_DIVIDE : F_PUSH;
        end
      end
      F_DIVIDE: begin
        if (!busy_new && !busy_old) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full   = (state != F_IDLE);
    q_push = (state == F_PUSH) && !q_full;
  end

  assign far = (col_diff >= COL_LIM) || (col_diff <= -COL_LIM) ||
               (row_diff >= ROW_LIM) || (row_diff <= -ROW_LIM);

  always_comb begin
    q_wdata.col_shift = SHIFT_W'(col_diff);
    q_wdata.row_shift = SHIFT_W'(row_diff);
    if (!is_update) begin
      q_wdata.kind = CMD_NONE;
    end else if (far) begin
      q_wdata.kind = CMD_FULL;
    end else begin
      q_wdata.kind = CMD_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= F_IDLE;
      prev_center      <= '0;
      last_update_time <= '0;
      updated_once     <= 1'b0;
      is_update        <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        is_update <= do_update;
        if (do_update) begin
          prev_center      <= item.center_tile;
          last_update_time <= item.now_ms;
          updated_once     <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_DIVIDE && !busy_new && !busy_old) begin
      col_diff <= $signed({1'b0, rem_new}) - $signed({1'b0, rem_old});
      row_diff <= $signed({1'b0, quot_new}) - $signed({1'b0, quot_old});
    end
  end

endmodule

[hw/rtl/twsp_cmdq.sv]
module twsp_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  twsp_pkg::cmd_t wdata,
  input  logic           pop,
  output twsp_pkg::cmd_t rdata,
  output logic           full,
  output logic           empty
);
  import twsp_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W + 1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

[hw/rtl/twsp_back.sv]
module twsp_back #(
  parameter int WINDOW_DIM = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  twsp_pkg::cmd_t q_rdata,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output twsp_pkg::out_t result
);
  import twsp_pkg::*;

  localparam int CW = (WINDOW_DIM > 1) ? $clog2(WINDOW_DIM) : 1;
  localparam logic [CW-1:0]          LAST_IX = CW'(WINDOW_DIM - 1);
  localparam logic signed [OFS_W-1:0] DIM_S  = OFS_W'(WINDOW_DIM);
  localparam logic [7:0]              DIM_B  = 8'(WINDOW_DIM);

  back_state_t state, state_next;

  cmd_t    cmd;
  logic [CW-1:0] a;  // outer index
  logic [CW-1:0] b;  // inner index
  logic    out_valid;
  out_t    out_data;

  logic    out_free;
  logic    emit;
  logic    at_end;
  logic    is_last;
  out_t    res;
  logic [CW-1:0] cc, rr;
  logic signed [OFS_W-1:0] co, ro;
  logic [7:0] dest_w, src_w, full_w;

  assign out_free = !out_valid || pop;
  assign at_end   = (a == LAST_IX) && (b == LAST_IX);
  assign is_last  = (cmd.kind == CMD_FULL || cmd.kind == CMD_SHIFT) ? at_end : 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = B_RUN;
        end
      end
      B_RUN: begin
        if (out_free && is_last) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == B_IDLE) && !q_empty;
    emit  = (state == B_RUN) && out_free;
  end

  // walk direction follows the sign of each shift
  always_comb begin
    cc     = cmd.col_shift[SHIFT_W-1] ? (LAST_IX - a) : a;
    rr     = cmd.row_shift[SHIFT_W-1] ? (LAST_IX - b) : b;
    co     = $signed(OFS_W'({1'b0, cc})) + OFS_W'($signed(cmd.col_shift));
    ro     = $signed(OFS_W'({1'b0, rr})) + OFS_W'($signed(cmd.row_shift));
    dest_w = 8'(cc) + 8'(rr) * DIM_B;
    src_w  = 8'(co[CW-1:0]) + 8'(ro[CW-1:0]) * DIM_B;
    full_w = 8'(b) + 8'(a) * DIM_B;
  end

  always_comb begin
    res.action      = ACT_NONE;
    res.dest_slot   = '0;
    res.src_slot    = '0;
    res.full_reload = 1'b0;
    res.last        = is_last;
    case (cmd.kind)
      CMD_FULL: begin
        res.action      = ACT_LOAD;
        res.dest_slot   = SLOT_W'(full_w);
        res.full_reload = 1'b1;
      end
      CMD_SHIFT: begin
        res.dest_slot = SLOT_W'(dest_w);
        if (co >= 0 && co < DIM_S && ro >= 0 && ro < DIM_S) begin
          res.action   = ACT_COPY;
          res.src_slot = SLOT_W'(src_w);
        end else begin
          res.action = ACT_LOAD;
        end
      end
      default: begin
        res.action = ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      a         <= '0;
      b         <= '0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        a <= '0;
        b <= '0;
      end else if (emit) begin
        if (b == LAST_IX) begin
          b <= '0;
          a <= a + 1'b1;
        end else begin
          b <= b + 1'b1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_rdata;
    end
    if (emit) begin
      out_data <= res;
    end
  end

  assign empty  = !out_valid;
  assign result = out_data;

endmodule

[hw/rtl/tile_window_scroll_planner_core.sv]
// Path: an update passes the 32-step serial divider in F_DIVIDE, then F_PUSH, the command
//   queue and the back end's command and output registers; a no-update skips the divider.
// The front takes a new item only once its command is queued; an update's results leave at
//   one per cycle while the consumer pops, WINDOW_DIM*WINDOW_DIM in all.
// Reset: synchronous, active high; clears config to defaults, center/time history, queues.
module tile_window_scroll_planner_core #(
  parameter int WINDOW_DIM = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  // input transactions
  input  logic                        push,
  input  twsp_pkg::in_t               in_item,
  output logic                        full,
  // result transactions
  input  logic                        pop,
  output logic                        empty,
  output twsp_pkg::out_t              result,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [twsp_pkg::ADDR_W-1:0] paddr,
  input  logic [twsp_pkg::DATA_W-1:0] pwdata,
  output logic [twsp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import twsp_pkg::*;

  // Structure:
  //   front  - takes a transaction, runs the debounce/tile-change check, and on an update
  //            splits old and new centers into column/row with two serial dividers running
  //            side by side, then classifies the move as none, full reload or shift.
  //   cmdq   - two-entry command queue so the front can start the next transaction while
  //            the back end is still emitting slot actions.
  //   back   - expands each command into result transactions through an output register.

  logic [CFG_W-1:0] tiles_per_row;
  logic [CFG_W-1:0] debounce_ms;
  logic             cfg_wr;

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_wdata, q_rdata;

  // APB: zero wait states; word select on paddr[2], byte lane bits ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tiles_per_row <= CFG_W'(1);
      debounce_ms   <= CFG_W'(1000);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TILES_PER_ROW: tiles_per_row <= pwdata[CFG_W-1:0];
        REG_DEBOUNCE_MS:   debounce_ms   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TILES_PER_ROW: prdata = {{(DATA_W-CFG_W){1'b0}}, tiles_per_row};
      REG_DEBOUNCE_MS:   prdata = {{(DATA_W-CFG_W){1'b0}}, debounce_ms};
      default:           prdata = '0;
    endcase
  end

  twsp_front #(
    .WINDOW_DIM (WINDOW_DIM)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .item          (in_item),
    .full          (full),
    .tiles_per_row (tiles_per_row),
    .debounce_ms   (debounce_ms),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  twsp_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // back end walks the window; the output register lets it run ahead of the consumer
  twsp_back #(
    .WINDOW_DIM (WINDOW_DIM)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

[tb/window_plan_checker.sv]
module window_plan_checker
  import twsp_pkg::*;
#(
  parameter int WINDOW_DIM = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  in_t               in_item,
  input  logic              pop,
  input  logic              empty,
  input  out_t              result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                errors,
  output int                pending,
  output int                items_seen,
  output int                updates_seen,
  output int                reloads_seen,
  output int                results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = WINDOW_DIM * WINDOW_DIM;

  logic [CFG_W-1:0]  tiles_per_row;
  logic [CFG_W-1:0]  debounce_ms;
  logic [TILE_W-1:0] prev_center;
  logic [TILE_W-1:0] last_update;
  logic              updated_once;

  out_t planned_moves[$];
  out_t want;
  int   n_err;
  int   n_items;
  int   n_upd;
  int   n_full;
  int   n_res;

  initial begin
    errors       = 0;
    pending      = 0;
    items_seen   = 0;
    updates_seen = 0;
    reloads_seen = 0;
    results_seen = 0;
    n_err        = 0;
    n_items      = 0;
    n_upd        = 0;
    n_full       = 0;
    n_res        = 0;
  end

  function automatic out_t make_move(act_t act, int dest, int src, logic whole, logic fin);
    out_t m;
    m.action      = act;
    m.dest_slot   = SLOT_W'(dest);
    m.src_slot    = SLOT_W'(src);
    m.full_reload = whole;
    m.last        = fin;
    return m;
  endfunction

  // one line per mismatch; the log is capped, the count is not
  task automatic flag_mismatch(input string what);
    if (n_err < 100) begin
      $display("MISMATCH at result %0d: %s", n_res, what);
    end
    n_err++;
  endtask

  task automatic plan_window_moves(input logic [TILE_W-1:0] center,
                                   input logic [TILE_W-1:0] now);
    logic [TILE_W-1:0] per_row;
    logic [TILE_W-1:0] elapsed;
    longint            cshift;
    longint            rshift;
    longint            c;
    longint            r;
    longint            cc;
    longint            rr;
    longint            co;
    longint            ro;
    int                idx;
    per_row = (tiles_per_row == '0) ? TILE_W'(1) : TILE_W'(tiles_per_row);
    elapsed = now - last_update;
    if (center == prev_center || (updated_once && elapsed <= TILE_W'(debounce_ms))) begin
      planned_moves.push_back(make_move(ACT_NONE, 0, 0, 1'b0, 1'b1));
      return;
    end
    cshift = longint'({32'b0, center % per_row}) - longint'({32'b0, prev_center % per_row});
    rshift = longint'({32'b0, center / per_row}) - longint'({32'b0, prev_center / per_row});
    n_upd++;
    if (cshift >= WINDOW_DIM || cshift <= -WINDOW_DIM ||
        rshift >= WINDOW_DIM || rshift <= -WINDOW_DIM) begin
      n_full++;
      for (idx = 0; idx < SLOTS; idx++) begin
        planned_moves.push_back(make_move(ACT_LOAD, idx, 0, 1'b1, idx == SLOTS - 1));
      end
    end else begin
      // walk away from the shift so no slot is overwritten before it is read
      idx = 0;
      for (c = 0; c < WINDOW_DIM; c++) begin
        for (r = 0; r < WINDOW_DIM; r++) begin
          cc = (cshift < 0) ? WINDOW_DIM - c - 1 : c;
          rr = (rshift < 0) ? WINDOW_DIM - r - 1 : r;
          co = cc + cshift;
          ro = rr + rshift;
          if (co >= 0 && co < WINDOW_DIM && ro >= 0 && ro < WINDOW_DIM) begin
            planned_moves.push_back(make_move(ACT_COPY, int'(cc + rr * WINDOW_DIM),
                                              int'(co + ro * WINDOW_DIM), 1'b0,
                                              idx == SLOTS - 1));
          end else begin
            planned_moves.push_back(make_move(ACT_LOAD, int'(cc + rr * WINDOW_DIM), 0,
                                              1'b0, idx == SLOTS - 1));
          end
          idx++;
        end
      end
    end
    prev_center  = center;
    last_update  = now;
    updated_once = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tiles_per_row = CFG_W'(1);
      debounce_ms   = CFG_W'(1000);
      prev_center   = '0;
      last_update   = '0;
      updated_once  = 1'b0;
      planned_moves.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TILES_PER_ROW) begin
          tiles_per_row = pwdata[CFG_W-1:0];
        end else begin
          debounce_ms = pwdata[CFG_W-1:0];
        end
      end
      if (pop && !empty) begin
        n_res++;
        if (planned_moves.size() == 0) begin
          flag_mismatch($sformatf("unexpected result %h with nothing pending", result));
        end else begin
          want = planned_moves.pop_front();
          if (result.action !== want.action)
            flag_mismatch($sformatf("action exp %0d got %0d", want.action, result.action));
          if (result.dest_slot !== want.dest_slot)
            flag_mismatch($sformatf("dest_slot exp %0d got %0d", want.dest_slot,
                                    result.dest_slot));
          if (result.src_slot !== want.src_slot)
            flag_mismatch($sformatf("src_slot exp %0d got %0d", want.src_slot,
                                    result.src_slot));
          if (result.full_reload !== want.full_reload)
            flag_mismatch($sformatf("full_reload exp %0b got %0b", want.full_reload,
                                    result.full_reload));
          if (result.last !== want.last)
            flag_mismatch($sformatf("last exp %0b got %0b", want.last, result.last));
        end
      end
      if (push && !full) begin
        n_items++;
        plan_window_moves(in_item.center_tile, in_item.now_ms);
      end
    end
    errors       <= n_err;
    pending      <= planned_moves.size();
    items_seen   <= n_items;
    updates_seen <= n_upd;
    reloads_seen <= n_full;
    results_seen <= n_res;
  end

endmodule

[tb/tile_window_scroll_planner_core_tb.sv]
module tile_window_scroll_planner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twsp_pkg::*;

  localparam int WINDOW_DIM       = 3;
  // long result stall: the block must fill up and push back on its input
  localparam int HOLD_CYCLES      = 400;
  // longest legal quiet stretch is the hold above plus one divide; keep ample margin
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int RANDOM_PER_PHASE = 25;
  localparam int RANDOM_PHASES    = 6;
  localparam int SETTLE_CYCLES    = 8;
  localparam int TAIL_CYCLES      = 40;

  localparam logic [ADDR_W-1:0] TPR_ADDR = {REG_TILES_PER_ROW, 2'b00};
  localparam logic [ADDR_W-1:0] DEB_ADDR = {REG_DEBOUNCE_MS, 2'b00};

  // kinds of random moves offered to the block
  typedef enum int {
    MV_NOISE,   // fully random tile and time
    MV_STAY,    // same tile, no update
    MV_BOUNCE,  // new tile inside the debounce window
    MV_JUMP,    // shift of a whole window or more
    MV_STEP     // small move, partial copy/load walk
  } move_kind_t;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              push    = 1'b0;
  in_t               in_item = '0;
  logic              full;
  logic              pop     = 1'b0;
  logic              empty;
  out_t              result;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches;
  int pending;
  int items_seen;
  int updates_seen;
  int reloads_seen;
  int results_seen;

  // stimulus-side view of the block: only used to shape well-formed moves
  logic [TILE_W-1:0] trk_center = '0;
  logic [TILE_W-1:0] trk_time   = '0;
  logic              trk_once   = 1'b0;
  logic [CFG_W-1:0]  cur_tpr    = CFG_W'(1);
  logic [CFG_W-1:0]  cur_deb    = CFG_W'(1000);

  int   send_streak = 0;
  int   take_streak = 0;
  int   n_settings  = 0;
  int   idle_cycles = 0;
  logic hold_req    = 1'b0;
  logic hold_done   = 1'b0;

  logic [CFG_W-1:0] phase_tpr [RANDOM_PHASES];
  logic [CFG_W-1:0] phase_deb [RANDOM_PHASES];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tile_window_scroll_planner_core #(
    .WINDOW_DIM(WINDOW_DIM)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .in_item(in_item),
    .full   (full),
    .pop    (pop),
    .empty  (empty),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  window_plan_checker #(
    .WINDOW_DIM(WINDOW_DIM)
  ) plan_check (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_item     (in_item),
    .pop         (pop),
    .empty       (empty),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .errors      (mismatches),
    .pending     (pending),
    .items_seen  (items_seen),
    .updates_seen(updates_seen),
    .reloads_seen(reloads_seen),
    .results_seen(results_seen)
  );

  // Idle draw shared by both sides: mostly a uniform random gap, with occasional
  // back-to-back streaks where nothing idles at all.
  function automatic int draw_gap(inout int streak);
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      streak = $urandom_range(5, 20);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  // Offer one input transaction and wait for the block to take it.
  // push stays high across back-to-back items; it only drops for a gap.
  task automatic send_item(input logic [TILE_W-1:0] center, input logic [TILE_W-1:0] now);
    int gap;
    gap = draw_gap(send_streak);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // center_tile is the upper field of the packed payload
    in_item <= {center, now};
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    // keep the shaping view in step with what the block will do
    if (center != trk_center && (!trk_once || (now - trk_time) > TILE_W'(cur_deb))) begin
      trk_center = center;
      trk_time   = now;
      trk_once   = 1'b1;
    end
  endtask

  // Mostly well-formed moves relative to the last update, some noise.
  task automatic send_random_item();
    move_kind_t        kind;
    int                pick;
    int                dc;
    int                dr;
    int                sgn;
    int                per;
    logic [TILE_W-1:0] center;
    logic [TILE_W-1:0] now;
    per  = (cur_tpr == '0) ? 1 : int'(cur_tpr);
    pick = $urandom_range(0, 9);
    kind = (pick == 0) ? MV_NOISE  :
           (pick == 1) ? MV_STAY   :
           (pick == 2) ? MV_BOUNCE :
           (pick == 3) ? MV_JUMP   : MV_STEP;
    dc     = int'($urandom_range(0, 4)) - 2;
    dr     = int'($urandom_range(0, 4)) - 2;
    sgn    = ($urandom_range(0, 1) == 0) ? 1 : -1;
    now    = trk_time + TILE_W'(cur_deb) + 1 + $urandom_range(0, 40);
    center = trk_center + TILE_W'(dc + dr * per);
    case (kind)
      MV_NOISE: begin
        center = $urandom;
        now    = $urandom;
      end
      MV_STAY: begin
        center = trk_center;
      end
      MV_BOUNCE: begin
        center = trk_center + 1;
        now    = trk_time + $urandom_range(0, int'(cur_deb));
      end
      MV_JUMP: begin
        if ($urandom_range(0, 1) == 0) begin
          dc = sgn * int'($urandom_range(3, 5));
        end else if ($urandom_range(0, 3) == 0) begin
          dr = sgn * int'($urandom_range(3, 2000));
        end else begin
          dr = sgn * int'($urandom_range(3, 5));
        end
        center = trk_center + TILE_W'(dc + dr * per);
      end
      default: begin
      end
    endcase
    send_item(center, now);
  endtask

  // APB write: setup cycle, then access cycle held until pready.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_W-1:0] tpr, input logic [CFG_W-1:0] deb);
    write_reg(TPR_ADDR, tpr);
    write_reg(DEB_ADDR, deb);
    cur_tpr = tpr;
    cur_deb = deb;
    n_settings++;
  endtask

  // Every input yields at least one result, so an empty expectation queue
  // means the block is done; a few more cycles let it settle to idle.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random stalls per transaction, plus one long hold-off
  // requested by the stimulus while the sender keeps pushing.
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(take_streak);
      if (hold_req && !hold_done) begin
        gap       = gap + HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // Watchdog: any accepted transaction on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    phase_tpr = '{CFG_W'(3), CFG_W'(65535), CFG_W'(7), CFG_W'(1), CFG_W'(12), CFG_W'(2)};
    phase_deb = '{CFG_W'(10), CFG_W'(0), CFG_W'(0), CFG_W'(65535), CFG_W'(300), CFG_W'(0)};
    phase_tpr[RANDOM_PHASES-1] = CFG_W'($urandom_range(2, 300));
    phase_deb[RANDOM_PHASES-1] = CFG_W'($urandom_range(0, 200));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- reset defaults: one tile per row, 1000 ms debounce ---
    send_item(32'd5, 32'd0);           // first update skips debounce; row jump -> full
    send_item(32'd5, 32'd5000);        // same tile -> none
    send_item(32'd6, 32'd500);         // too soon -> none
    send_item(32'd6, 32'd1000);        // elapsed equals debounce -> still none
    send_item(32'd6, 32'd1001);        // row +1, partial
    send_item(32'd4, 32'd2100);        // row -2, partial walking upward

    // --- 8 per row, no debounce: every shift sign and the full-reload edges ---
    wait_drained();
    configure(CFG_W'(8), CFG_W'(0));
    send_item(32'd13, 32'd1);          // time wrapped since last update; +1,+1
    send_item(32'd4, 32'd2);           // -1,-1
    send_item(32'd35, 32'd3);          // row +4 -> full
    send_item(32'd21, 32'd4);          // +2,-2
    send_item(32'd35, 32'd5);          // -2,+2
    send_item(32'd43, 32'd6);          // 0,+1
    send_item(32'd46, 32'd7);          // column +3 -> full
    send_item(32'd22, 32'd8);          // row -3 -> full
    send_item(32'd22, 32'd9);          // same tile -> none
    send_item(32'd23, 32'd8);          // zero elapsed with zero debounce -> none
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFF6, 32'd4);   // time wraps; -1,-1 near the top of the range
    send_item(32'd0, 32'd10);

    // --- zero tiles per row acts as one; largest debounce ---
    wait_drained();
    configure(CFG_W'(0), CFG_W'(65535));
    send_item(32'd1, 32'd70000);
    send_item(32'd2, 32'd135535);      // elapsed exactly at debounce -> none
    send_item(32'd0, 32'd135536);      // one past -> update, row -1

    // --- random phases, each under its own register setting ---
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      configure(phase_tpr[p], phase_deb[p]);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        // stall the result side for a long stretch early in one phase
        if (p == 1 && i == 4) begin
          hold_req = 1'b1;
        end
        send_random_item();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d input and %0d result transactions: %0d window updates, %0d full reloads.",
             items_seen, results_seen, updates_seen, reloads_seen);
    $display("Ran %0d register settings incl. zero and full-scale values, one long result stall.",
             n_settings);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
